// ===== hw/rtl/ssmp_pkg.sv =====
// Package for the sequence store mismatch percent block.
// Holds the request/result word types, request codes and controller interface structs.
// No dependencies.
`default_nettype none

package ssmp_pkg;

    localparam int REQ_W     = 3;
    localparam int PAT_W     = 16;
    localparam int PCT_W     = 7;
    localparam int CNT_W     = 5;
    localparam int QC_W      = 16;
    localparam int K_W       = 3;
    localparam int PCT_SCALE = 100;

    localparam logic [QC_W-1:0] QC_MAX = {QC_W{1'b1}};

    localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_APPEND  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_FULL    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_PARTIAL = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DELETE  = 3'd4;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [PAT_W-1:0] pattern;
        logic             last;
    } ssmp_req_t;

    typedef struct packed {
        logic [PCT_W-1:0] percent;
        logic             done_res;
        logic [CNT_W-1:0] stored_count;
        logic             status;
    } ssmp_res_t;

    typedef struct packed {
        logic ld_in;
        logic clear_store;
        logic append;
        logic end_query;
        logic cmp_read;
        logic cmp_eval;
        logic div_init;
        logic div_step;
        logic del_init;
        logic del_read;
        logic del_eval;
        logic del_done;
        logic out_load;
    } ssmp_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             last;
        logic             rd_lt_len;
        logic             div_last;
        logic             out_free;
    } ssmp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ssmp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ssmp_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ssmp_ctrl.sv =====
// Controller state machine for the sequence store mismatch percent block.
// Depends on ssmp_pkg; drives ssmp_dp through command/status structs.
`default_nettype none

module ssmp_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire ssmp_pkg::ssmp_stat_t stat,
    output ssmp_pkg::ssmp_cmd_t     cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_EXEC     = 3'd1;
    localparam logic [2:0] S_CMP      = 3'd2;
    localparam logic [2:0] S_DIV_INIT = 3'd3;
    localparam logic [2:0] S_DIV      = 3'd4;
    localparam logic [2:0] S_DEL_RD   = 3'd5;
    localparam logic [2:0] S_DEL_EV   = 3'd6;
    localparam logic [2:0] S_FIN      = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.ld_in  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (stat.req_type) inside
                    ssmp_pkg::REQ_CLEAR:
                    begin
                        cmd.clear_store = 1'b1;
                        cmd.end_query   = 1'b1;
                        state_next      = S_FIN;
                    end
                    ssmp_pkg::REQ_APPEND:
                    begin
                        cmd.append    = 1'b1;
                        cmd.end_query = 1'b1;
                        state_next    = S_FIN;
                    end
                    ssmp_pkg::REQ_FULL, ssmp_pkg::REQ_PARTIAL:
                    begin
                        cmd.cmp_read = 1'b1;
                        state_next   = S_CMP;
                    end
                    ssmp_pkg::REQ_DELETE:
                    begin
                        cmd.del_init  = 1'b1;
                        cmd.end_query = 1'b1;
                        state_next    = S_DEL_RD;
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_CMP:
            begin
                cmd.cmp_eval = 1'b1;
                state_next   = stat.last ? S_DIV_INIT : S_FIN;
            end
            S_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_DEL_RD:
            begin
                if (stat.rd_lt_len)
                begin
                    cmd.del_read = 1'b1;
                    state_next   = S_DEL_EV;
                end
                else
                begin
                    cmd.del_done = 1'b1;
                    state_next   = S_FIN;
                end
            end
            S_DEL_EV:
            begin
                cmd.del_eval = 1'b1;
                state_next   = S_DEL_RD;
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ssmp_dp.sv =====
// Datapath for the sequence store mismatch percent block: store, counters, divider, result.
// Depends on ssmp_pkg and ssmp_ram; commanded by ssmp_ctrl.
`default_nettype none

module ssmp_dp #(
    parameter int DEPTH = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ssmp_pkg::ssmp_req_t  req_word,
    output ssmp_pkg::ssmp_res_t       res_word,
    output logic                      res_valid,
    input  wire logic                 res_stall,
    input  wire ssmp_pkg::ssmp_cmd_t  cmd,
    output ssmp_pkg::ssmp_stat_t      stat
);

    localparam int LEN_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NUM_W  = $clog2(DEPTH * ssmp_pkg::PCT_SCALE + 1);
    localparam int CMP_W  = ssmp_pkg::QC_W + ssmp_pkg::PCT_W - 1;

    localparam logic [LEN_W-1:0]         LEN_MAX  = LEN_W'(DEPTH);
    localparam logic [LEN_W:0]           DEPTH_X  = (LEN_W + 1)'(DEPTH);
    localparam logic [ssmp_pkg::QC_W-1:0] DEPTH_QC = ssmp_pkg::QC_W'(DEPTH);
    localparam logic [ssmp_pkg::K_W-1:0]  K_START  = ssmp_pkg::K_W'(ssmp_pkg::PCT_W - 1);

    ssmp_pkg::ssmp_req_t           req_reg;
    ssmp_pkg::ssmp_res_t           res_reg;
    logic                          res_valid_reg;
    logic                          res_valid_next;
    logic [LEN_W-1:0]              len_reg;
    logic [LEN_W-1:0]              len_next;
    logic [ssmp_pkg::QC_W-1:0]     qc_reg;
    logic [ssmp_pkg::QC_W-1:0]     qc_next;
    logic [LEN_W-1:0]              mm_reg;
    logic [LEN_W-1:0]              mm_next;
    logic [LEN_W-1:0]              rd_reg;
    logic [LEN_W-1:0]              rd_next;
    logic [LEN_W-1:0]              wr_reg;
    logic [LEN_W-1:0]              wr_next;
    logic [NUM_W-1:0]              rem_reg;
    logic [NUM_W-1:0]              rem_next;
    logic [ssmp_pkg::QC_W-1:0]     dvs_reg;
    logic [ssmp_pkg::QC_W-1:0]     dvs_next;
    logic [ssmp_pkg::PCT_W-1:0]    q_reg;
    logic [ssmp_pkg::PCT_W-1:0]    q_next;
    logic [ssmp_pkg::K_W-1:0]      k_reg;
    logic [ssmp_pkg::K_W-1:0]      k_next;
    logic                          done_reg;
    logic                          done_next;
    logic                          status_reg;
    logic                          status_next;

    logic                          has_room;
    logic                          qc_hit;
    logic [LEN_W-1:0]              lmin;
    logic [LEN_W:0]                diff;
    logic [NUM_W-1:0]              num_full;
    logic [NUM_W-1:0]              num_part;
    logic [CMP_W-1:0]              trial;
    logic                          take;
    logic                          keep;
    logic                          is_full;

    logic                          ram_wr_en;
    logic [ADDR_W-1:0]             ram_wr_addr;
    logic [ssmp_pkg::PAT_W-1:0]    ram_wr_data;
    logic                          ram_rd_en;
    logic [ADDR_W-1:0]             ram_rd_addr;
    logic [ssmp_pkg::PAT_W-1:0]    ram_rd_data;

    ssmp_ram #(
        .WIDTH (ssmp_pkg::PAT_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign has_room = (len_reg < LEN_MAX);
    assign qc_hit   = (qc_reg < ssmp_pkg::QC_W'(len_reg));
    assign lmin     = qc_hit ? qc_reg[LEN_W-1:0] : len_reg;
    assign diff     = DEPTH_X - {1'b0, lmin} + {1'b0, mm_reg};
    assign num_full = NUM_W'(diff * ssmp_pkg::PCT_SCALE);
    assign num_part = NUM_W'(mm_reg * ssmp_pkg::PCT_SCALE);
    assign trial    = CMP_W'(dvs_reg) << k_reg;
    assign take     = (CMP_W'(rem_reg) >= trial);
    assign keep     = (ram_rd_data != req_reg.pattern);
    assign is_full  = (req_reg.req_type == ssmp_pkg::REQ_FULL);

    assign ram_wr_en   = (cmd.append && has_room) || (cmd.del_eval && keep);
    assign ram_wr_addr = cmd.del_eval ? wr_reg[ADDR_W-1:0] : len_reg[ADDR_W-1:0];
    assign ram_wr_data = cmd.del_eval ? ram_rd_data : req_reg.pattern;
    assign ram_rd_en   = cmd.cmp_read || cmd.del_read;
    assign ram_rd_addr = cmd.del_read ? rd_reg[ADDR_W-1:0] : qc_reg[ADDR_W-1:0];

    assign stat.req_type  = req_reg.req_type;
    assign stat.last      = req_reg.last;
    assign stat.rd_lt_len = (rd_reg < len_reg);
    assign stat.div_last  = (k_reg == '0);
    assign stat.out_free  = !res_valid_reg || !res_stall;

    assign res_word  = res_reg;
    assign res_valid = res_valid_reg;

    always_comb
    begin
        len_next       = len_reg;
        qc_next        = qc_reg;
        mm_next        = mm_reg;
        rd_next        = rd_reg;
        wr_next        = wr_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        q_next         = q_reg;
        k_next         = k_reg;
        done_next      = done_reg;
        status_next    = status_reg;
        res_valid_next = res_valid_reg;

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
        if (cmd.ld_in)
        begin
            done_next   = 1'b0;
            status_next = 1'b0;
        end
        if (cmd.clear_store)
        begin
            len_next = '0;
        end
        if (cmd.append)
        begin
            if (has_room)
            begin
                len_next = len_reg + 1'b1;
            end
            else
            begin
                status_next = 1'b1;
            end
        end
        if (cmd.end_query)
        begin
            qc_next = '0;
            mm_next = '0;
        end
        if (cmd.cmp_eval)
        begin
            if (qc_hit && (ram_rd_data != req_reg.pattern))
            begin
                mm_next = mm_reg + 1'b1;
            end
            if (qc_reg != ssmp_pkg::QC_MAX)
            begin
                qc_next = qc_reg + 1'b1;
            end
        end
        if (cmd.div_init)
        begin
            rem_next  = is_full ? num_full : num_part;
            dvs_next  = is_full ? DEPTH_QC : qc_reg;
            q_next    = '0;
            k_next    = K_START;
            done_next = 1'b1;
            qc_next   = '0;
            mm_next   = '0;
        end
        if (cmd.div_step)
        begin
            if (take)
            begin
                rem_next      = rem_reg - trial[NUM_W-1:0];
                q_next[k_reg] = 1'b1;
            end
            k_next = k_reg - 1'b1;
        end
        if (cmd.del_init)
        begin
            rd_next = '0;
            wr_next = '0;
        end
        if (cmd.del_eval)
        begin
            rd_next = rd_reg + 1'b1;
            if (keep)
            begin
                wr_next = wr_reg + 1'b1;
            end
        end
        if (cmd.del_done)
        begin
            len_next = wr_reg;
        end
        if (cmd.out_load)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            qc_reg        <= '0;
            mm_reg        <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            qc_reg        <= qc_next;
            mm_reg        <= mm_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_in)
        begin
            req_reg <= req_word;
        end
        if (cmd.out_load)
        begin
            res_reg.percent      <= done_reg ? q_reg : '0;
            res_reg.done_res     <= done_reg;
            res_reg.stored_count <= ssmp_pkg::CNT_W'(len_reg);
            res_reg.status       <= status_reg;
        end
        rd_reg     <= rd_next;
        wr_reg     <= wr_next;
        rem_reg    <= rem_next;
        dvs_reg    <= dvs_next;
        q_reg      <= q_next;
        k_reg      <= k_next;
        done_reg   <= done_next;
        status_reg <= status_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sequence_store_mismatch_percent.sv =====
// Top level of the sequence store mismatch percent block.
// Depends on ssmp_pkg, ssmp_ctrl, ssmp_dp (which holds ssmp_ram).
//
// Holds up to DEPTH 16-bit pattern ids in one single-port-read RAM and takes one request word
// at a time, giving exactly one result word per request. Clear, append and unused codes go
// straight to the result; a compare element first reads the RAM and then compares; the
// element that ends a query then runs the divider, one setup step and then one quotient bit
// per cycle. A delete reads each stored element and then conditionally writes it back
// through the store's one read and one write port. A new request is taken as soon as the
// previous result sits in the output register.
`default_nettype none

module sequence_store_mismatch_percent #(
    parameter int DEPTH = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire ssmp_pkg::ssmp_req_t req_word,
    output logic                     res_valid,
    input  wire logic                res_stall,
    output ssmp_pkg::ssmp_res_t      res_word
);

    ssmp_pkg::ssmp_cmd_t  cmd;
    ssmp_pkg::ssmp_stat_t stat;

    ssmp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    ssmp_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_word  (req_word),
        .res_word  (res_word),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire
